>>> hw/rtl/mas_pkg.sv
// ----------------------------------------------------------------------------
// mas_pkg: shared types and constants for the matrix add/sub/multiply engine
// Holds the transaction structs, command and operation codes, register
// indexes and field widths used by the engine and its storage.
// ----------------------------------------------------------------------------
`default_nettype none

package mas_pkg;

  // Default largest matrix dimension
  localparam int MAS_MAX_DIM = 8;

  // Field widths
  localparam int ELEM_W   = 16;  // signed Q8.8 element
  localparam int RESULT_W = 40;  // signed Q24.16 result
  localparam int IDX_W    = 3;   // row / column field
  localparam int CMD_W    = 2;
  localparam int DIM_W    = 4;   // dimension register
  localparam int OP_W     = 2;

  // Configuration port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // Commands
  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN     = 2'd2;

  // Operations
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 3'd4;

  // Input transaction
  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] value;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [IDX_W-1:0]           out_row;
    logic [IDX_W-1:0]           out_col;
    logic signed [RESULT_W-1:0] result_value;
    logic                       status;
    logic                       last;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/mas_ram.sv
// ----------------------------------------------------------------------------
// mas_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/matrix_add_sub_multiply.sv
// ----------------------------------------------------------------------------
// matrix_add_sub_multiply: matrix add, subtract and multiply engine
// Loads matrices A and B element by element, then streams A+B, A-B or A*B.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a transaction is taken when start is high and busy low.
//   Write commands store one Q8.8 element of A or B and never raise busy;
//   a row or column of MAX_DIM or more is dropped. A run command
//   streams the result of the operation register in row-major order.
//   Result channel: out_valid marks each result for exactly one cycle; the
//   receiver cannot stall it. The last element carries last=1.
//   Configuration: cfg_ready is always high; write only while busy is low.
//   Timing: one multiplier/adder unit does one step per cycle. A run
//   issues rows*cols steps for add/sub and rows_a*cols_b*cols_a steps for
//   multiply, one memory read of each matrix per step; each result then
//   passes the read data, product or sum, and accumulator registers. A
//   dimension mismatch gives one error result (status=1, last=1) the cycle
//   after the run command, with no busy time.
//   Reset: synchronous, active low; clears the sequencer and the registers
//   to 1x1 dimensions and add. Matrix storage keeps no reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_add_sub_multiply
  import mas_pkg::*;
#(
  parameter int MAX_DIM = MAS_MAX_DIM
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_data,
  // result channel
  output logic                       out_valid,
  output out_item_t                  out_data,
  // configuration channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Sequencer state codes
  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_ISSUE = 1'b1;

  // Configuration registers
  logic [DIM_W-1:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic [OP_W-1:0]  op_r;

  logic             state_r, state_nxt;
  logic [DIM_W-1:0] r_r, r_nxt, c_r, c_nxt, z_r, z_nxt;

  // Stage 1: memory read data
  logic             v1_r, first1_r, endz1_r, last1_r;
  logic [DIM_W-1:0] row1_r, col1_r;
  // Stage 2: product or sum
  logic                       v2_r, first2_r, endz2_r, last2_r;
  logic [DIM_W-1:0]           row2_r, col2_r;
  logic signed [RESULT_W-1:0] p2_r;
  // Stage 3: accumulator and output
  logic signed [RESULT_W-1:0] acc_r, acc_sum;
  logic                       out_valid_r;
  out_item_t                  out_data_r;

  logic             accept, wr_go, run_go, dims_ok, mul_op;
  logic [DIM_W-1:0] nr, nc, nz;
  logic             z_end, c_end, r_end;
  logic [AW-1:0]    wr_addr, rd_addr_a, rd_addr_b;
  logic [ELEM_W-1:0] a_rdata, b_rdata;
  logic signed [ELEM_W-1:0]   a_s, b_s;
  logic signed [ELEM_W:0]     s17;
  logic signed [2*ELEM_W-1:0] prod;
  logic signed [RESULT_W-1:0] p_nxt;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r == ST_ISSUE) || v1_r || v2_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign accept    = start && !busy;
  assign mul_op    = (op_r == OP_MUL);

  // Decode accepted transaction
  assign wr_go  = accept && ((in_data.command == CMD_WRITE_A) ||
                             (in_data.command == CMD_WRITE_B)) &&
                  (32'(in_data.row) < MAX_DIM) && (32'(in_data.col) < MAX_DIM);
  assign run_go = accept && (in_data.command == CMD_RUN);
  assign wr_addr = AW'(32'(in_data.row) * MAX_DIM + 32'(in_data.col));

  // Check dimensions against the operation
  always_comb begin
    logic all_ok;
    all_ok = (rows_a_r != '0) && (32'(rows_a_r) <= MAX_DIM) &&
             (cols_a_r != '0) && (32'(cols_a_r) <= MAX_DIM) &&
             (rows_b_r != '0) && (32'(rows_b_r) <= MAX_DIM) &&
             (cols_b_r != '0) && (32'(cols_b_r) <= MAX_DIM);
    unique case (op_r)
      OP_ADD, OP_SUB: dims_ok = all_ok && (rows_a_r == rows_b_r) &&
                                (cols_a_r == cols_b_r);
      OP_MUL:         dims_ok = all_ok && (cols_a_r == rows_b_r);
      default:        dims_ok = 1'b0;
    endcase
  end

  // Loop bounds
  assign nr = rows_a_r;
  assign nc = mul_op ? cols_b_r : cols_a_r;
  assign nz = mul_op ? cols_a_r : DIM_W'(1);
  assign z_end = (z_r == nz - DIM_W'(1));
  assign c_end = (c_r == nc - DIM_W'(1));
  assign r_end = (r_r == nr - DIM_W'(1));

  // Advance row, column and inner counters
  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    z_nxt     = z_r;
    unique case (state_r)
      ST_IDLE: begin
        if (run_go && dims_ok) begin
          state_nxt = ST_ISSUE;
          r_nxt     = '0;
          c_nxt     = '0;
          z_nxt     = '0;
        end
      end
      ST_ISSUE: begin
        if (!z_end) begin
          z_nxt = z_r + DIM_W'(1);
        end else begin
          z_nxt = '0;
          if (!c_end) begin
            c_nxt = c_r + DIM_W'(1);
          end else begin
            c_nxt = '0;
            r_nxt = r_r + DIM_W'(1);
            if (r_end) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    c_r <= c_nxt;
    z_r <= z_nxt;
  end

  // Read addresses: A(r, z) and B(z, c) for multiply, A(r, c), B(r, c) else
  assign rd_addr_a = AW'(32'(r_r) * MAX_DIM + 32'(mul_op ? z_r : c_r));
  assign rd_addr_b = AW'(32'(mul_op ? z_r : r_r) * MAX_DIM + 32'(c_r));

  mas_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_go && (in_data.command == CMD_WRITE_A)),
    .wr_addr (wr_addr),
    .wr_data (in_data.value),
    .rd_addr (rd_addr_a),
    .rd_data (a_rdata)
  );

  mas_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_go && (in_data.command == CMD_WRITE_B)),
    .wr_addr (wr_addr),
    .wr_data (in_data.value),
    .rd_addr (rd_addr_b),
    .rd_data (b_rdata)
  );

  // Stage 1: carry step tags alongside the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= (state_r == ST_ISSUE);
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= (z_r == '0);
    endz1_r  <= z_end;
    last1_r  <= r_end && c_end;
    row1_r   <= r_r;
    col1_r   <= c_r;
  end

  // Shared arithmetic unit: Q8.8 product, or Q8.8 sum scaled to Q24.16
  assign a_s  = signed'(a_rdata);
  assign b_s  = signed'(b_rdata);
  assign prod = a_s * b_s;
  assign s17  = (op_r == OP_SUB) ? (ELEM_W+1)'(a_s) - (ELEM_W+1)'(b_s)
                                 : (ELEM_W+1)'(a_s) + (ELEM_W+1)'(b_s);
  assign p_nxt = mul_op ? RESULT_W'(prod) : (RESULT_W'(s17) <<< 8);

  // Stage 2: register the unit output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p2_r     <= p_nxt;
    first2_r <= first1_r;
    endz2_r  <= endz1_r;
    last2_r  <= last1_r;
    row2_r   <= row1_r;
    col2_r   <= col1_r;
  end

  // Stage 3: accumulate and emit on the final inner step
  assign acc_sum = first2_r ? p2_r : acc_r + p2_r;

  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc_r <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (v2_r && endz2_r) || (run_go && !dims_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (run_go && !dims_ok) begin
      out_data_r.out_row      <= '0;
      out_data_r.out_col      <= '0;
      out_data_r.result_value <= '0;
      out_data_r.status       <= 1'b1;
      out_data_r.last         <= 1'b1;
    end else if (v2_r && endz2_r) begin
      out_data_r.out_row      <= row2_r[IDX_W-1:0];
      out_data_r.out_col      <= col2_r[IDX_W-1:0];
      out_data_r.result_value <= acc_sum;
      out_data_r.status       <= 1'b0;
      out_data_r.last         <= last2_r;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_W'(1);
      cols_a_r <= DIM_W'(1);
      rows_b_r <= DIM_W'(1);
      cols_b_r <= DIM_W'(1);
      op_r     <= OP_ADD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROWS_A:    rows_a_r <= cfg_data[DIM_W-1:0];
        REG_COLS_A:    cols_a_r <= cfg_data[DIM_W-1:0];
        REG_ROWS_B:    rows_b_r <= cfg_data[DIM_W-1:0];
        REG_COLS_B:    cols_b_r <= cfg_data[DIM_W-1:0];
        REG_OPERATION: op_r     <= cfg_data[OP_W-1:0];
        default: ;
      endcase
    end
  end

  // Error results are always single and final
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status |-> out_data_r.last)
    else $error("error result without last");

  // A run either reports an error or starts issuing steps
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    run_go |=> (out_valid_r && out_data_r.status) || (state_r == ST_ISSUE))
    else $error("run command neither started nor rejected");

  // Final inner step yields a result on the next cycle
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && endz2_r |=> out_valid_r && !out_data_r.status)
    else $error("completed element not emitted");

  // Pipeline is empty once the last result is shown
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last |-> !v1_r && !v2_r && (state_r == ST_IDLE))
    else $error("last result shown with work in flight");

endmodule

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for matrix_add_sub_multiply
// Loads A and B through the command port, programs dimensions and operation
// through the register port, and checks every streamed result element
// against a behavioral model of add, subtract and multiply, including the
// dimension-mismatch error result. A short directed table runs first, then
// random load-and-run sequences under three sender pacing phases.
// ----------------------------------------------------------------------------
module testbench
  import mas_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_ITEMS  = 360;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int STORE_DEPTH   = MAS_MAX_DIM * MAS_MAX_DIM;

  // Codes the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [OP_W-1:0]  OP_BAD     = 2'd3;

  // One row of the directed table: a register write or a command
  typedef struct {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              item;
    logic                  typed;
    out_item_t             typed_res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_data;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Model state: element stores, written flags and register copies
  logic signed [ELEM_W-1:0] a_store [STORE_DEPTH];
  logic signed [ELEM_W-1:0] b_store [STORE_DEPTH];
  logic [STORE_DEPTH-1:0]   a_written;
  logic [STORE_DEPTH-1:0]   b_written;
  logic [DIM_W-1:0]         rows_a_cfg;
  logic [DIM_W-1:0]         cols_a_cfg;
  logic [DIM_W-1:0]         rows_b_cfg;
  logic [DIM_W-1:0]         cols_b_cfg;
  logic [OP_W-1:0]          op_cfg;

  out_item_t step_results[$];
  out_item_t expected_elems[$];
  stim_row_t directed_rows[$];

  int idle_pct;
  int cycle_count = 0;
  int fault_count;
  int items_accepted;
  int runs_accepted;
  int error_runs;
  int elems_checked;

  matrix_add_sub_multiply dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // End the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic dim_in_range(input logic [DIM_W-1:0] d);
    return d >= 1 && d <= MAS_MAX_DIM;
  endfunction

  // Decide whether the programmed dimensions suit the programmed operation
  function automatic logic run_fits();
    logic dims_ok;
    dims_ok = dim_in_range(rows_a_cfg) && dim_in_range(cols_a_cfg) &&
              dim_in_range(rows_b_cfg) && dim_in_range(cols_b_cfg);
    case (op_cfg)
      OP_ADD, OP_SUB: return dims_ok && rows_a_cfg == rows_b_cfg &&
                             cols_a_cfg == cols_b_cfg;
      OP_MUL:         return dims_ok && cols_a_cfg == rows_b_cfg;
      default:        return 1'b0;
    endcase
  endfunction

  // Apply one command to the model and collect the elements it streams
  function automatic void predict_matrix_op(input in_item_t it);
    int                 idx;
    int                 n_rows;
    int                 n_cols;
    logic signed [63:0] acc;
    logic signed [63:0] lhs;
    logic signed [63:0] rhs;
    out_item_t          res;
    step_results.delete();
    idx = int'(it.row) * MAS_MAX_DIM + int'(it.col);
    case (it.command)
      CMD_WRITE_A: begin
        a_store[idx]   = it.value;
        a_written[idx] = 1'b1;
      end
      CMD_WRITE_B: begin
        b_store[idx]   = it.value;
        b_written[idx] = 1'b1;
      end
      CMD_RUN: begin
        if (!run_fits()) begin
          res = '{out_row: '0, out_col: '0, result_value: '0, status: 1'b1, last: 1'b1};
          step_results.push_back(res);
        end else begin
          n_rows = int'(rows_a_cfg);
          n_cols = int'((op_cfg == OP_MUL) ? cols_b_cfg : cols_a_cfg);
          for (int r = 0; r < n_rows; r++) begin
            for (int c = 0; c < n_cols; c++) begin
              acc = '0;
              if (op_cfg == OP_MUL) begin
                for (int z = 0; z < cols_a_cfg; z++) begin
                  lhs = 64'(a_store[r * MAS_MAX_DIM + z]);
                  rhs = 64'(b_store[z * MAS_MAX_DIM + c]);
                  acc += lhs * rhs;
                end
              end else begin
                lhs = 64'(a_store[r * MAS_MAX_DIM + c]);
                rhs = 64'(b_store[r * MAS_MAX_DIM + c]);
                acc = ((op_cfg == OP_ADD) ? lhs + rhs : lhs - rhs) * 256;
              end
              res.out_row      = IDX_W'(r);
              res.out_col      = IDX_W'(c);
              res.result_value = acc[RESULT_W-1:0];
              res.status       = 1'b0;
              res.last         = (r == n_rows - 1) && (c == n_cols - 1);
              step_results.push_back(res);
            end
          end
        end
      end
      default: ;  // unused command: ignored
    endcase
  endfunction

  // Mostly random element values, with the extremes mixed in
  function automatic logic [ELEM_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    if ($urandom_range(9) == 0) return DIM_W'(MAS_MAX_DIM);
    return DIM_W'($urandom_range(4, 1));
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    stim_row_t s;
    s.is_cfg    = 1'b1;
    s.reg_idx   = idx;
    s.reg_val   = val;
    s.item      = '0;
    s.typed     = 1'b0;
    s.typed_res = '0;
    return s;
  endfunction

  function automatic stim_row_t item_row(input logic [CMD_W-1:0] cmd,
                                         input logic [IDX_W-1:0] r,
                                         input logic [IDX_W-1:0] c,
                                         input logic [ELEM_W-1:0] v);
    stim_row_t s;
    s = cfg_row('0, '0);
    s.is_cfg       = 1'b0;
    s.item.command = cmd;
    s.item.row     = r;
    s.item.col     = c;
    s.item.value   = v;
    return s;
  endfunction

  // A run whose single element is known by inspection
  function automatic stim_row_t typed_run(input logic st,
                                          input logic signed [RESULT_W-1:0] v);
    stim_row_t s;
    s = item_row(CMD_RUN, '0, '0, '0);
    s.typed     = 1'b1;
    s.typed_res = '{out_row: '0, out_col: '0, result_value: v, status: st, last: 1'b1};
    return s;
  endfunction

  // Present one command, hold it until accepted, then record what it causes
  task automatic send_item(input in_item_t it, input logic use_typed,
                           input out_item_t typed_res);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_matrix_op(it);
    if (use_typed) step_results[0] = typed_res;
    foreach (step_results[i]) expected_elems.push_back(step_results[i]);
    if (it.command == CMD_RUN) begin
      runs_accepted++;
      if (step_results[0].status) error_runs++;
    end
    items_accepted++;
  endtask

  task automatic load_element(input logic [CMD_W-1:0] cmd, input int idx);
    in_item_t it;
    it.command = cmd;
    it.row     = IDX_W'(idx / MAS_MAX_DIM);
    it.col     = IDX_W'(idx % MAS_MAX_DIM);
    it.value   = pick_value();
    send_item(it, 1'b0, '0);
  endtask

  // Drop start and wait until the engine has streamed everything pending
  task automatic settle_engine();
    start <= 1'b0;
    @(posedge clk);
    while (expected_elems.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROWS_A:    rows_a_cfg = val;
      REG_COLS_A:    cols_a_cfg = val;
      REG_ROWS_B:    rows_b_cfg = val;
      REG_COLS_B:    cols_b_cfg = val;
      REG_OPERATION: op_cfg     = val[OP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      fault_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Compare each streamed element with the oldest pending one
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_elems.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result: expected none, got row %0d col %0d value %0d",
                 $time, out_data.out_row, out_data.out_col, out_data.result_value);
      end else begin
        want = expected_elems.pop_front();
        check_field("out_row", 64'(want.out_row), 64'(out_data.out_row));
        check_field("out_col", 64'(want.out_col), 64'(out_data.out_col));
        check_field("result_value", 64'(want.result_value),
                    64'(out_data.result_value));
        check_field("status", 64'(want.status), 64'(out_data.status));
        check_field("last", 64'(want.last), 64'(out_data.last));
        elems_checked++;
      end
    end
  end

  initial begin
    stim_row_t        row;
    in_item_t         it;
    logic             broken;
    logic [DIM_W-1:0] new_ra;
    logic [DIM_W-1:0] new_ca;
    logic [DIM_W-1:0] new_rb;
    logic [DIM_W-1:0] new_cb;
    logic [OP_W-1:0]  new_op;
    int               rand_items;
    int               drain_wait;

    // Hold every input at a known value through reset
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    fault_count    = 0;
    items_accepted = 0;
    runs_accepted  = 0;
    error_runs     = 0;
    elems_checked  = 0;
    a_written      = '0;
    b_written      = '0;
    rows_a_cfg     = DIM_W'(1);
    cols_a_cfg     = DIM_W'(1);
    rows_b_cfg     = DIM_W'(1);
    cols_b_cfg     = DIM_W'(1);
    op_cfg         = OP_ADD;
    idle_pct       = 7;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: reset registers, value extremes, every operation,
    // every kind of dimension mismatch, the unused command, index extremes
    directed_rows.push_back(item_row(CMD_WRITE_A, '0, '0, 16'h7FFF));
    directed_rows.push_back(item_row(CMD_WRITE_B, '0, '0, 16'h7FFF));
    directed_rows.push_back(typed_run(1'b0, 40'sd16776704));
    directed_rows.push_back(cfg_row(REG_OPERATION, CFG_DATA_W'(OP_SUB)));
    directed_rows.push_back(item_row(CMD_WRITE_B, '0, '0, 16'h8000));
    directed_rows.push_back(typed_run(1'b0, 40'sd16776960));
    directed_rows.push_back(cfg_row(REG_OPERATION, CFG_DATA_W'(OP_MUL)));
    directed_rows.push_back(item_row(CMD_WRITE_A, '0, '0, 16'h8000));
    directed_rows.push_back(typed_run(1'b0, 40'sd1073741824));
    directed_rows.push_back(item_row(CMD_WRITE_B, '0, '0, 16'h7FFF));
    directed_rows.push_back(typed_run(1'b0, -40'sd1073709056));
    directed_rows.push_back(cfg_row(REG_OPERATION, CFG_DATA_W'(OP_ADD)));
    directed_rows.push_back(typed_run(1'b0, -40'sd256));
    directed_rows.push_back(cfg_row(REG_OPERATION, CFG_DATA_W'(OP_BAD)));
    directed_rows.push_back(typed_run(1'b1, 40'sd0));
    directed_rows.push_back(cfg_row(REG_OPERATION, CFG_DATA_W'(OP_ADD)));
    directed_rows.push_back(cfg_row(REG_ROWS_A, '0));
    directed_rows.push_back(typed_run(1'b1, 40'sd0));
    directed_rows.push_back(cfg_row(REG_ROWS_A, CFG_DATA_W'(15)));
    directed_rows.push_back(typed_run(1'b1, 40'sd0));
    directed_rows.push_back(cfg_row(REG_ROWS_A, CFG_DATA_W'(2)));
    directed_rows.push_back(typed_run(1'b1, 40'sd0));
    directed_rows.push_back(cfg_row(REG_ROWS_A, CFG_DATA_W'(1)));
    directed_rows.push_back(cfg_row(REG_COLS_B, CFG_DATA_W'(2)));
    directed_rows.push_back(typed_run(1'b1, 40'sd0));
    directed_rows.push_back(cfg_row(REG_OPERATION, CFG_DATA_W'(OP_MUL)));
    directed_rows.push_back(item_row(CMD_WRITE_B, '0, IDX_W'(1), 16'h0100));
    directed_rows.push_back(item_row(CMD_RUN, '0, '0, 16'h0000));
    directed_rows.push_back(cfg_row(REG_COLS_A, CFG_DATA_W'(2)));
    directed_rows.push_back(typed_run(1'b1, 40'sd0));
    directed_rows.push_back(item_row(CMD_UNUSED, IDX_W'(7), IDX_W'(7), 16'hFFFF));
    directed_rows.push_back(item_row(CMD_WRITE_A, IDX_W'(7), IDX_W'(7), 16'h0000));
    directed_rows.push_back(item_row(CMD_WRITE_B, IDX_W'(7), IDX_W'(7), 16'hFFFF));

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        settle_engine();
        write_register(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.item, row.typed, row.typed_res);
      end
    end

    // Random load-and-run sequences; sender pacing changes by thirds
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items < RANDOM_ITEMS / 3) idle_pct = 7;
      else if (rand_items < 2 * RANDOM_ITEMS / 3) idle_pct = 49;
      else idle_pct = 0;

      // Pick a setting: mostly consistent shapes, some arbitrary ones
      broken = ($urandom_range(99) < 15);
      if (broken) begin
        new_op = OP_W'($urandom_range(3));
        new_ra = DIM_W'($urandom_range(15));
        new_ca = DIM_W'($urandom_range(15));
        new_rb = DIM_W'($urandom_range(15));
        new_cb = DIM_W'($urandom_range(15));
      end else begin
        new_op = OP_W'($urandom_range(2));
        if ($urandom_range(11) == 0) begin
          new_ra = DIM_W'(MAS_MAX_DIM);
          new_ca = DIM_W'(MAS_MAX_DIM);
          new_cb = DIM_W'(MAS_MAX_DIM);
        end else begin
          new_ra = pick_dim();
          new_ca = pick_dim();
          new_cb = pick_dim();
        end
        new_rb = (new_op == OP_MUL) ? new_ca : new_ra;
        if (new_op != OP_MUL) new_cb = new_ca;
      end

      settle_engine();
      write_register(REG_ROWS_A, new_ra);
      write_register(REG_COLS_A, new_ca);
      write_register(REG_ROWS_B, new_rb);
      write_register(REG_COLS_B, new_cb);
      write_register(REG_OPERATION, CFG_DATA_W'(new_op));

      // Load every element the run reads that is not yet written, refresh
      // some others, and sprinkle in ignored commands and stray writes
      for (int idx = 0; idx < STORE_DEPTH; idx++) begin
        if ($urandom_range(99) < 4) begin
          it.command = CMD_UNUSED;
          it.row     = IDX_W'($urandom_range(7));
          it.col     = IDX_W'($urandom_range(7));
          it.value   = pick_value();
          send_item(it, 1'b0, '0);
          rand_items++;
        end
        if ($urandom_range(99) < 3) begin
          load_element($urandom_range(1) ? CMD_WRITE_B : CMD_WRITE_A,
                       $urandom_range(STORE_DEPTH - 1));
          rand_items++;
        end
        if (run_fits() && idx / MAS_MAX_DIM < rows_a_cfg &&
            idx % MAS_MAX_DIM < cols_a_cfg &&
            (!a_written[idx] || $urandom_range(99) < 30)) begin
          load_element(CMD_WRITE_A, idx);
          rand_items++;
        end
        if (run_fits() && idx / MAS_MAX_DIM < rows_b_cfg &&
            idx % MAS_MAX_DIM < cols_b_cfg &&
            (!b_written[idx] || $urandom_range(99) < 30)) begin
          load_element(CMD_WRITE_B, idx);
          rand_items++;
        end
      end

      // Run, sometimes twice back to back, sometimes with loads queued behind
      it.command = CMD_RUN;
      it.row     = IDX_W'($urandom_range(7));
      it.col     = IDX_W'($urandom_range(7));
      it.value   = pick_value();
      send_item(it, 1'b0, '0);
      rand_items++;
      if ($urandom_range(99) < 25) begin
        send_item(it, 1'b0, '0);
        rand_items++;
      end
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(3, 1)) begin
          load_element($urandom_range(1) ? CMD_WRITE_B : CMD_WRITE_A,
                       $urandom_range(STORE_DEPTH - 1));
          rand_items++;
        end
      end
    end

    // Drain what is still pending, then give the engine its latency
    start <= 1'b0;
    drain_wait = 0;
    while ((expected_elems.size() != 0 || busy) && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_elems.size() != 0) begin
      fault_count += expected_elems.size();
      $display("%0t: %0d result elements never arrived", $time, expected_elems.size());
    end

    $display("Accepted %0d transactions, %0d of them runs (%0d dimension errors);",
             items_accepted, runs_accepted, error_runs);
    $display("checked %0d result elements across add, subtract and multiply.",
             elems_checked);
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
